[sv/c3sg_pkg.sv]
// Shared types, constants and tables for the 3x3 convolution / Sobel gradient filter.
package c3sg_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int COEF_BITS_DEF  = 16;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int CONV_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int SLOT_W     = 16;
    localparam int SIZE_CFG_W = 11;
    // Frame sizes are compared at this width (covers sizes up to 8191)
    localparam int DIM_W      = 13;

    localparam int MIN_DIM    = 3;
    localparam int SIZE_RESET = 1024;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KMODE  = 3'd0,
        REG_KTOP   = 3'd1,
        REG_KMID   = 3'd2,
        REG_KBOT   = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } t_reg;

    // Kernel select
    typedef enum logic [1:0] {
        KM_USER    = 2'd0,
        KM_SOBEL_X = 2'd1,
        KM_SOBEL_Y = 2'd2
    } t_kmode;

    // Fixed masks, row-major, top row first, 3-bit two's complement
    localparam logic [2:0] SOBEL_X [9] = '{
        3'b111, 3'b000, 3'b001,
        3'b110, 3'b000, 3'b010,
        3'b111, 3'b000, 3'b001
    };
    localparam logic [2:0] SOBEL_Y [9] = '{
        3'b001, 3'b010, 3'b001,
        3'b000, 3'b000, 3'b000,
        3'b111, 3'b110, 3'b111
    };

    // Fraction byte of 256*r/9 for a remainder r of a division by 9
    function automatic logic [PIX_W-1:0] frac9(input logic [3:0] rem);
        logic [PIX_W-1:0] f;
        case (rem)
            4'd0:    f = 8'd0;
            4'd1:    f = 8'd28;
            4'd2:    f = 8'd56;
            4'd3:    f = 8'd85;
            4'd4:    f = 8'd113;
            4'd5:    f = 8'd142;
            4'd6:    f = 8'd170;
            4'd7:    f = 8'd199;
            4'd8:    f = 8'd227;
            default: f = 8'd0;
        endcase
        return f;
    endfunction

endpackage

[sv/conv3x3_sobel_gradient.sv]
// Top level: configuration registers, frame size clamp and the filter pipeline.
//
// Streaming 3x3 convolution over 8-bit grayscale pixels in raster order, one
// pixel word in per clock while the output is not stalled, with the Sobel X
// mask, the Sobel Y mask or a user kernel of signed coefficients; any other
// mode selects none and yields nothing. Each pixel that closes an interior
// window yields one result word, (window sum * 256) / 9 truncated toward zero
// in signed fixed point with 8 fraction bits, plus the window centre position
// and a last-of-frame flag; border pixels yield nothing. The pipeline has nine
// register stages. The rate is set by the line store, a MAX_WIDTH x 16 RAM
// holding the two previous rows, which is read once and written once per
// pixel; back-to-back reads and writes of one entry are forwarded. The RAM is
// not cleared after reset: the first two rows of a frame fill it before any
// result depends on it. Write the configuration only while the pipeline is
// empty.
module conv3x3_sobel_gradient #(
    parameter int MAX_WIDTH  = c3sg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3sg_pkg::MAX_HEIGHT_DEF,
    parameter int COEF_BITS  = c3sg_pkg::COEF_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [c3sg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [c3sg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // pixel words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [c3sg_pkg::PIX_W-1:0]          i_pixel,
    input  logic                                i_frame_start,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [c3sg_pkg::CONV_W-1:0]  o_conv_value,
    output logic [$clog2(MAX_HEIGHT)-1:0]       o_center_row,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_center_col,
    output logic                                o_frame_last
);
    import c3sg_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int RS_W = COEF_BITS + PIX_W + 2;

    logic [1:0]                  r_kmode;
    logic [2:0][CFG_DATA_W-1:0]  r_krow;
    logic [SIZE_CFG_W-1:0]       r_width, r_height;

    logic [DIM_W-1:0]            cfg_w, cfg_h, width_c, height_c;

    logic                        lb_valid, lb_take, lb_emit, lb_last;
    logic [PIX_W-1:0]            lb_pixel, lb_above1, lb_above2;
    logic [RW-1:0]               lb_row;
    logic [CW-1:0]               lb_col;

    logic                        wm_valid, wm_take, wm_last;
    logic [2:0][RS_W-1:0]        wm_rsum;
    logic [RW-1:0]               wm_row;
    logic [CW-1:0]               wm_col;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmode  <= KM_SOBEL_X;
            r_krow   <= '0;
            r_width  <= SIZE_CFG_W'(SIZE_RESET);
            r_height <= SIZE_CFG_W'(SIZE_RESET);
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_KMODE:  r_kmode   <= i_cfg_data[1:0];
                REG_KTOP:   r_krow[0] <= i_cfg_data;
                REG_KMID:   r_krow[1] <= i_cfg_data;
                REG_KBOT:   r_krow[2] <= i_cfg_data;
                REG_WIDTH:  r_width   <= i_cfg_data[SIZE_CFG_W-1:0];
                REG_HEIGHT: r_height  <= i_cfg_data[SIZE_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame size clamped to 3..MAX
    assign cfg_w    = DIM_W'(r_width);
    assign cfg_h    = DIM_W'(r_height);
    assign width_c  = (cfg_w < DIM_W'(MIN_DIM))   ? DIM_W'(MIN_DIM)   :
                      (cfg_w > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_w;
    assign height_c = (cfg_h < DIM_W'(MIN_DIM))    ? DIM_W'(MIN_DIM)    :
                      (cfg_h > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_h;

    c3sg_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_width       (width_c),
        .i_height      (height_c),
        .i_take        (lb_take),
        .o_valid       (lb_valid),
        .o_pixel       (lb_pixel),
        .o_above1      (lb_above1),
        .o_above2      (lb_above2),
        .o_emit        (lb_emit),
        .o_row         (lb_row),
        .o_col         (lb_col),
        .o_last        (lb_last)
    );

    c3sg_window_mac #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COEF_BITS  (COEF_BITS)
    ) u_window_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (lb_valid),
        .o_take   (lb_take),
        .i_pixel  (lb_pixel),
        .i_above1 (lb_above1),
        .i_above2 (lb_above2),
        .i_emit   (lb_emit),
        .i_row    (lb_row),
        .i_col    (lb_col),
        .i_last   (lb_last),
        .i_kmode  (r_kmode),
        .i_krows  (r_krow),
        .i_take   (wm_take),
        .o_valid  (wm_valid),
        .o_rsum   (wm_rsum),
        .o_row    (wm_row),
        .o_col    (wm_col),
        .o_last   (wm_last)
    );

    c3sg_scale #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COEF_BITS  (COEF_BITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (wm_valid),
        .o_take       (wm_take),
        .i_rsum       (wm_rsum),
        .i_row        (wm_row),
        .i_col        (wm_col),
        .i_last       (wm_last),
        .i_take       (i_out_ready),
        .o_valid      (o_out_valid),
        .o_conv_value (o_conv_value),
        .o_row        (o_center_row),
        .o_col        (o_center_col),
        .o_last       (o_frame_last)
    );
endmodule

[sv/c3sg_ram.sv]
// Generic simple dual-port RAM, one write and one registered read per cycle.
module c3sg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/c3sg_line_buf.sv]
// Raster position counters and the two-row line store with its read-modify-write stage.
module c3sg_line_buf #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel word in
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [c3sg_pkg::PIX_W-1:0]    i_pixel,
    input  logic                          i_frame_start,
    // clamped frame size
    input  logic [c3sg_pkg::DIM_W-1:0]    i_width,
    input  logic [c3sg_pkg::DIM_W-1:0]    i_height,
    // stage 1 out
    input  logic                          i_take,
    output logic                          o_valid,
    output logic [c3sg_pkg::PIX_W-1:0]    o_pixel,
    output logic [c3sg_pkg::PIX_W-1:0]    o_above1,
    output logic [c3sg_pkg::PIX_W-1:0]    o_above2,
    output logic                          o_emit,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_col,
    output logic                          o_last
);
    import c3sg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = 2 * PIX_W;

    logic [CW-1:0]    r_col, n_col, cur_col;
    logic [RW-1:0]    r_row, n_row, cur_row;

    logic             r_v1;
    logic [PIX_W-1:0] r_px;
    logic [CW-1:0]    r_addr;
    logic             r_emit;
    logic [RW-1:0]    r_ctr_row;
    logic [CW-1:0]    r_ctr_col;
    logic             r_last;
    logic             r_fwd;
    logic [LW-1:0]    r_fwd_data;

    logic             load1, accept, wr_en;
    logic [LW-1:0]    rd_data, line_data, wr_data;
    logic             col_wrap, row_wrap;

    assign load1      = !r_v1 || i_take;
    assign o_in_ready = load1;
    assign accept     = i_in_valid && load1;
    // the word in stage 1 writes its entry back as it moves on
    assign wr_en      = r_v1 && i_take;
    // entry holds {row r-2, row r-1}
    assign line_data  = r_fwd ? r_fwd_data : rd_data;
    assign wr_data    = {line_data[PIX_W-1:0], r_px};

    // Position of the arriving pixel and the position after it
    always_comb begin
        cur_col = i_frame_start ? '0 : r_col;
        cur_row = i_frame_start ? '0 : r_row;
        if (DIM_W'(cur_col) >= i_width) begin
            cur_col = '0;
        end
        if (DIM_W'(cur_row) >= i_height) begin
            cur_row = '0;
        end
        col_wrap = (DIM_W'(cur_col) + DIM_W'(1)) >= i_width;
        row_wrap = (DIM_W'(cur_row) + DIM_W'(1)) >= i_height;
        n_col = cur_col + CW'(1);
        n_row = cur_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : cur_row + RW'(1);
        end
    end

    // Counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1: line store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (load1) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px       <= i_pixel;
            r_addr     <= cur_col;
            r_emit     <= (cur_row >= RW'(2)) && (cur_col >= CW'(2));
            r_ctr_row  <= cur_row - RW'(1);
            r_ctr_col  <= cur_col - CW'(1);
            r_last     <= col_wrap && row_wrap;
            // same entry written this cycle: take the new data instead of the RAM
            r_fwd      <= wr_en && (r_addr == cur_col);
            r_fwd_data <= wr_data;
        end
    end

    c3sg_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (rd_data)
    );

    assign o_valid  = r_v1;
    assign o_pixel  = r_px;
    assign o_above1 = line_data[PIX_W-1:0];
    assign o_above2 = line_data[LW-1:PIX_W];
    assign o_emit   = r_emit;
    assign o_row    = r_ctr_row;
    assign o_col    = r_ctr_col;
    assign o_last   = r_last;
endmodule

[sv/c3sg_window_mac.sv]
// 3x3 window register, kernel select, nine products and the three row sums.
module c3sg_window_mac #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COEF_BITS  = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // from the line buffer
    input  logic                                    i_valid,
    output logic                                    o_take,
    input  logic [c3sg_pkg::PIX_W-1:0]              i_pixel,
    input  logic [c3sg_pkg::PIX_W-1:0]              i_above1,
    input  logic [c3sg_pkg::PIX_W-1:0]              i_above2,
    input  logic                                    i_emit,
    input  logic [$clog2(MAX_HEIGHT)-1:0]           i_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]            i_col,
    input  logic                                    i_last,
    // kernel configuration
    input  logic [1:0]                              i_kmode,
    input  logic [2:0][c3sg_pkg::CFG_DATA_W-1:0]    i_krows,
    // row sums out
    input  logic                                    i_take,
    output logic                                    o_valid,
    output logic [2:0][COEF_BITS+c3sg_pkg::PIX_W+1:0] o_rsum,
    output logic [$clog2(MAX_HEIGHT)-1:0]           o_row,
    output logic [$clog2(MAX_WIDTH)-1:0]            o_col,
    output logic                                    o_last
);
    import c3sg_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int P_W  = COEF_BITS + PIX_W + 1;
    localparam int RS_W = P_W + 1;

    logic [PIX_W-1:0]            r_win [9];
    logic                        r_v2, r_v3, r_v4;
    logic                        r_emit2;
    logic [RW-1:0]               r_row2, r_row3, r_row4;
    logic [CW-1:0]               r_col2, r_col3, r_col4;
    logic                        r_last2, r_last3, r_last4;
    logic signed [P_W-1:0]       r_prod [9];
    logic signed [RS_W-1:0]      r_rsum [3];

    logic                        ld2, ld3, ld4;
    logic                        mode_ok;
    logic signed [COEF_BITS-1:0] coef [9];

    assign ld4    = !r_v4 || i_take;
    assign ld3    = !r_v3 || ld4;
    assign ld2    = !r_v2 || ld3;
    assign o_take = ld2;

    assign mode_ok = (i_kmode == KM_USER) || (i_kmode == KM_SOBEL_X)
                  || (i_kmode == KM_SOBEL_Y);

    // Coefficient select
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                case (t_kmode'(i_kmode))
                    KM_USER:
                        coef[i*3+j] = i_krows[i][SLOT_W*j +: COEF_BITS];
                    KM_SOBEL_X:
                        coef[i*3+j] = {{(COEF_BITS-3){SOBEL_X[i*3+j][2]}},
                                       SOBEL_X[i*3+j]};
                    KM_SOBEL_Y:
                        coef[i*3+j] = {{(COEF_BITS-3){SOBEL_Y[i*3+j][2]}},
                                       SOBEL_Y[i*3+j]};
                    default:
                        coef[i*3+j] = '0;
                endcase
            end
        end
    end

    // Window shift: one column per word, newest column on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_valid && ld2) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3+0] <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2] <= i_above2;
            r_win[5] <= i_above1;
            r_win[8] <= i_pixel;
        end
    end

    // Stage valids; only interior words with a valid kernel mode go past the window stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld2) begin
                r_v2 <= i_valid;
            end
            if (ld3) begin
                r_v3 <= r_v2 && r_emit2 && mode_ok;
            end
            if (ld4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 2: position info of the window just formed
    always_ff @(posedge i_clk) begin
        if (i_valid && ld2) begin
            r_emit2 <= i_emit;
            r_row2  <= i_row;
            r_col2  <= i_col;
            r_last2 <= i_last;
        end
    end

    // Stage 3: products
    always_ff @(posedge i_clk) begin
        if (ld3) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= P_W'(coef[k]) * P_W'($signed({1'b0, r_win[k]}));
            end
            r_row3  <= r_row2;
            r_col3  <= r_col2;
            r_last3 <= r_last2;
        end
    end

    // Stage 4: row sums
    always_ff @(posedge i_clk) begin
        if (ld4) begin
            for (int i = 0; i < 3; i++) begin
                r_rsum[i] <= RS_W'(r_prod[i*3]) + RS_W'(r_prod[i*3+1])
                           + RS_W'(r_prod[i*3+2]);
            end
            r_row4  <= r_row3;
            r_col4  <= r_col3;
            r_last4 <= r_last3;
        end
    end

    assign o_valid   = r_v4;
    assign o_rsum[0] = r_rsum[0];
    assign o_rsum[1] = r_rsum[1];
    assign o_rsum[2] = r_rsum[2];
    assign o_row     = r_row4;
    assign o_col     = r_col4;
    assign o_last    = r_last4;
endmodule

[sv/c3sg_scale.sv]
// Final sum and scaling by 256/9 truncated toward zero, with the output register.
module c3sg_scale #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COEF_BITS  = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // row sums in
    input  logic                                      i_valid,
    output logic                                      o_take,
    input  logic [2:0][COEF_BITS+c3sg_pkg::PIX_W+1:0] i_rsum,
    input  logic [$clog2(MAX_HEIGHT)-1:0]             i_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]              i_col,
    input  logic                                      i_last,
    // result word out
    input  logic                                      i_take,
    output logic                                      o_valid,
    output logic signed [c3sg_pkg::CONV_W-1:0]        o_conv_value,
    output logic [$clog2(MAX_HEIGHT)-1:0]             o_row,
    output logic [$clog2(MAX_WIDTH)-1:0]              o_col,
    output logic                                      o_last
);
    import c3sg_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int RS_W  = COEF_BITS + PIX_W + 2;
    localparam int SUM_W = RS_W + 2;
    localparam int N_W   = SUM_W - 1;
    localparam int M_W   = N_W + 1;
    localparam int SH    = N_W + 4;
    localparam int MP_W  = N_W + M_W;
    localparam int Q_W   = N_W - 3;
    localparam int MAG_W = Q_W + PIX_W;
    // ceil(2^SH / 9): exact quotient for any magnitude below 2^N_W
    localparam longint unsigned M_VAL = ((64'd1 << SH) + 64'd8) / 64'd9;
    localparam logic [M_W-1:0] M_RECIP = M_W'(M_VAL);

    logic                     r_v5, r_v6, r_v7, r_v8, r_v9;
    logic signed [SUM_W-1:0]  r_sum;
    logic [N_W-1:0]           r_n6, r_n7;
    logic [MP_W-1:0]          r_mp;
    logic [Q_W-1:0]           r_q8;
    logic [3:0]               r_rem;
    logic                     r_neg6, r_neg7, r_neg8;
    logic signed [CONV_W-1:0] r_conv;
    logic [RW-1:0]            r_row [5];
    logic [CW-1:0]            r_col [5];
    logic                     r_last [5];

    logic                     ld5, ld6, ld7, ld8, ld9;
    logic [SUM_W-1:0]         abs_sum;
    logic [Q_W-1:0]           q7;
    logic [N_W-1:0]           nine_q, rem_full;
    logic [MAG_W-1:0]         mag;
    logic [CONV_W-1:0]        mag_ext;

    assign ld9    = !r_v9 || i_take;
    assign ld8    = !r_v8 || ld9;
    assign ld7    = !r_v7 || ld8;
    assign ld6    = !r_v6 || ld7;
    assign ld5    = !r_v5 || ld6;
    assign o_take = ld5;

    assign abs_sum  = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign q7       = r_mp[SH +: Q_W];
    assign nine_q   = N_W'({q7, 3'b000}) + N_W'(q7);
    assign rem_full = r_n7 - nine_q;
    // 256*n/9 = 256*q + floor(256*rem/9)
    assign mag      = {r_q8, frac9(r_rem)};
    assign mag_ext  = CONV_W'(mag);

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else begin
            if (ld5) begin
                r_v5 <= i_valid;
            end
            if (ld6) begin
                r_v6 <= r_v5;
            end
            if (ld7) begin
                r_v7 <= r_v6;
            end
            if (ld8) begin
                r_v8 <= r_v7;
            end
            if (ld9) begin
                r_v9 <= r_v8;
            end
        end
    end

    // Stage 5: window sum
    always_ff @(posedge i_clk) begin
        if (ld5) begin
            r_sum     <= SUM_W'($signed(i_rsum[0])) + SUM_W'($signed(i_rsum[1]))
                       + SUM_W'($signed(i_rsum[2]));
            r_row[0]  <= i_row;
            r_col[0]  <= i_col;
            r_last[0] <= i_last;
        end
    end

    // Stage 6: sign and magnitude
    always_ff @(posedge i_clk) begin
        if (ld6) begin
            r_neg6    <= r_sum[SUM_W-1];
            r_n6      <= abs_sum[N_W-1:0];
            r_row[1]  <= r_row[0];
            r_col[1]  <= r_col[0];
            r_last[1] <= r_last[0];
        end
    end

    // Stage 7: reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (ld7) begin
            r_mp      <= MP_W'(r_n6) * MP_W'(M_RECIP);
            r_n7      <= r_n6;
            r_neg7    <= r_neg6;
            r_row[2]  <= r_row[1];
            r_col[2]  <= r_col[1];
            r_last[2] <= r_last[1];
        end
    end

    // Stage 8: quotient and remainder by 9
    always_ff @(posedge i_clk) begin
        if (ld8) begin
            r_q8      <= q7;
            r_rem     <= rem_full[3:0];
            r_neg8    <= r_neg7;
            r_row[3]  <= r_row[2];
            r_col[3]  <= r_col[2];
            r_last[3] <= r_last[2];
        end
    end

    // Stage 9: output register, sign restored
    always_ff @(posedge i_clk) begin
        if (ld9) begin
            r_conv    <= r_neg8 ? -$signed(mag_ext) : $signed(mag_ext);
            r_row[4]  <= r_row[3];
            r_col[4]  <= r_col[3];
            r_last[4] <= r_last[3];
        end
    end

    assign o_valid      = r_v9;
    assign o_conv_value = r_conv;
    assign o_row        = r_row[4];
    assign o_col        = r_col[4];
    assign o_last       = r_last[4];
endmodule

[tb/tb_conv3x3_sobel_gradient.sv]
// Self-checking testbench for the 3x3 convolution / Sobel gradient filter.
module tb_conv3x3_sobel_gradient;
    timeunit 1ns;
    timeprecision 1ps;

    import c3sg_pkg::*;

    localparam int MAXW         = 1024;
    localparam int MAXH         = 1024;
    localparam int ROW_W        = $clog2(MAXH);
    localparam int COL_W        = $clog2(MAXW);
    localparam int RAND_WORDS   = 420;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int STUCK_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 40;

    // mode 3 selects no kernel; indexes 6 and 7 are not registers
    localparam logic [1:0]           KM_OFF     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;

    localparam int GRAD_X [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    localparam int GRAD_Y [9] = '{1, 2, 1, 0, 0, 0, -1, -2, -1};

    typedef struct {
        logic signed [CONV_W-1:0] value;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     last;
    } t_conv_result;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data    = '0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic [PIX_W-1:0]              i_pixel       = '0;
    logic                          i_frame_start = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b0;
    logic signed [CONV_W-1:0]      o_conv_value;
    logic [ROW_W-1:0]              o_center_row;
    logic [COL_W-1:0]              o_center_col;
    logic                          o_frame_last;

    // predictor state
    logic [PIX_W-1:0]      line_mem [2*MAXW];
    logic [PIX_W-1:0]      win [9];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [1:0]            kmode;
    logic [CFG_DATA_W-1:0] krow [3];
    logic [SIZE_CFG_W-1:0] img_w;
    logic [SIZE_CFG_W-1:0] img_h;
    t_conv_result          conv_q [$];
    t_conv_result          want;

    int errors       = 0;
    int reports      = 0;
    int hold_left    = 0;
    int stall_left   = 0;
    int stuck_cycles = 0;
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;
    bit hold_req     = 1'b0;

    conv3x3_sobel_gradient #(
        .MAX_WIDTH  (MAXW),
        .MAX_HEIGHT (MAXH),
        .COEF_BITS  (16)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_conv_value  (o_conv_value),
        .o_center_row  (o_center_row),
        .o_center_col  (o_center_col),
        .o_frame_last  (o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    task automatic model_reset();
        int k;
        for (k = 0; k < 2*MAXW; k++) line_mem[k] = '0;
        for (k = 0; k < 9; k++) win[k] = '0;
        col_pos = 0;
        row_pos = 0;
        kmode   = KM_SOBEL_X;
        for (k = 0; k < 3; k++) krow[k] = '0;
        img_w   = SIZE_CFG_W'(SIZE_RESET);
        img_h   = SIZE_CFG_W'(SIZE_RESET);
    endtask

    function automatic void model_write(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_KMODE:  kmode   = data[1:0];
            REG_KTOP:   krow[0] = data;
            REG_KMID:   krow[1] = data;
            REG_KBOT:   krow[2] = data;
            REG_WIDTH:  img_w   = data[SIZE_CFG_W-1:0];
            REG_HEIGHT: img_h   = data[SIZE_CFG_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int unsigned clamp_dim(logic [SIZE_CFG_W-1:0] v, int unsigned maxv);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    function automatic int cur_frame_words();
        return clamp_dim(img_w, MAXW) * clamp_dim(img_h, MAXH);
    endfunction

    // shift one pixel into the window; queue a result when the window is interior
    function automatic void predict_conv(logic [PIX_W-1:0] px, logic fs);
        int unsigned  w, h, c, r;
        int           k;
        logic [PIX_W-1:0] up1, up2;
        longint       sum, coef;
        t_conv_result res;
        w = clamp_dim(img_w, MAXW);
        h = clamp_dim(img_h, MAXH);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;

        // low half of the line memory holds row r-1, high half row r-2
        up1 = line_mem[c];
        up2 = line_mem[MAXW + c];
        for (k = 0; k < 3; k++) begin
            win[3*k]   = win[3*k+1];
            win[3*k+1] = win[3*k+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = px;
        line_mem[MAXW + c] = up1;
        line_mem[c]        = px;

        if (r >= 2 && c >= 2 && kmode != KM_OFF) begin
            sum = 0;
            for (k = 0; k < 9; k++) begin
                case (kmode)
                    KM_SOBEL_X: coef = GRAD_X[k];
                    KM_SOBEL_Y: coef = GRAD_Y[k];
                    default:    coef = longint'($signed(krow[k/3][SLOT_W*(k%3) +: SLOT_W]));
                endcase
                sum += coef * longint'(win[k]);
            end
            // signed division truncates toward zero
            res.value = CONV_W'((sum * 256) / 9);
            res.row   = ROW_W'(r - 1);
            res.col   = COL_W'(c - 1);
            res.last  = (r == h - 1) && (c == w - 1);
            conv_q.push_back(res);
        end

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // ---------------------------------------------------------------- result checking

    task automatic note_mismatch(string field, longint exp_v, longint act_v);
        errors++;
        if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (conv_q.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: result word expected none actual value %0d row %0d col %0d",
                             $time, o_conv_value, o_center_row, o_center_col);
                end
            end else begin
                want = conv_q.pop_front();
                if (o_conv_value !== want.value)
                    note_mismatch("conv_value", want.value, o_conv_value);
                if (o_center_row !== want.row)
                    note_mismatch("center_row", want.row, o_center_row);
                if (o_center_col !== want.col)
                    note_mismatch("center_col", want.col, o_center_col);
                if (o_frame_last !== want.last)
                    note_mismatch("frame_last", want.last, o_frame_last);
            end
        end
    end

    // result side: random stall bursts plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog: no word moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, STUCK_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coef_row();
        logic [CFG_DATA_W-1:0] row;
        int s;
        for (s = 0; s < 3; s++) begin
            case ($urandom_range(0, 5))
                0:       row[SLOT_W*s +: SLOT_W] = 16'h8000;
                1:       row[SLOT_W*s +: SLOT_W] = 16'h7FFF;
                2:       row[SLOT_W*s +: SLOT_W] = SLOT_W'($urandom_range(0, 8) - 4);
                default: row[SLOT_W*s +: SLOT_W] = SLOT_W'($urandom);
            endcase
        end
        return row;
    endfunction

    // one pixel word; the prediction is made on acceptance
    task automatic send_word(logic [PIX_W-1:0] px, logic fs);
        if (send_idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel       <= px;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_conv(px, fs);
    endtask

    // random pixels; restart_odds gives a 1-in-N chance of a mid-frame frame start
    task automatic send_frame(int words, logic fs_first, int restart_odds);
        int   k;
        logic fs;
        for (k = 0; k < words; k++) begin
            if (k == 0)
                fs = fs_first;
            else
                fs = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
            send_word(rand_pixel(), fs);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_write(idx, data);
    endtask

    task automatic set_size(int w, int h);
        write_reg(REG_WIDTH,  {32'($urandom), 5'($urandom), SIZE_CFG_W'(w)});
        write_reg(REG_HEIGHT, {32'($urandom), 5'($urandom), SIZE_CFG_W'(h)});
    endtask

    // sender stops until every expected result has arrived
    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (conv_q.size() != 0);
    endtask

    // pipeline empty, including pixels that make no result
    task automatic settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    // fixed masks on 3x3 frames; mode left at its reset value first
    task automatic test_sobel_directed();
        int k;
        write_reg(REG_WIDTH,  48'd0);   // below range, clamps to 3
        write_reg(REG_HEIGHT, 48'd2);
        // dark left, bright right
        for (k = 0; k < 9; k++) send_word((k % 3 == 2) ? 8'hFF : 8'h00, k == 0);
        // bright left: negative gradient, next frame without a frame start
        for (k = 0; k < 9; k++) send_word((k % 3 == 0) ? 8'hFF : 8'h00, 1'b0);
        settle();
        write_reg(REG_KMODE, CFG_DATA_W'(KM_SOBEL_Y));
        for (k = 0; k < 9; k++) send_word((k < 3) ? 8'hFF : 8'h00, k == 0);
    endtask

    // user coefficients: full-scale sums of both signs, then random kernels
    task automatic test_user_kernel();
        int k, n;
        settle();
        write_reg(REG_KMODE, CFG_DATA_W'(KM_USER));
        write_reg(REG_KTOP, {3{16'h8000}});
        write_reg(REG_KMID, {3{16'h8000}});
        write_reg(REG_KBOT, {3{16'h8000}});
        for (k = 0; k < 9; k++) send_word(8'hFF, k == 0);
        settle();
        write_reg(REG_KTOP, {3{16'h7FFF}});
        write_reg(REG_KMID, {3{16'h7FFF}});
        write_reg(REG_KBOT, {3{16'h7FFF}});
        for (k = 0; k < 9; k++) send_word(8'hFF, k == 0);
        settle();
        // writes past the register list change nothing
        write_reg(REG_SPARE0, {16'($urandom), 32'($urandom)});
        write_reg(REG_SPARE1, {16'($urandom), 32'($urandom)});
        for (k = 0; k < 9; k++) send_word(rand_pixel(), k == 0);
        for (n = 0; n < 6; n++) begin
            settle();
            write_reg(REG_KTOP, rand_coef_row());
            write_reg(REG_KMID, rand_coef_row());
            write_reg(REG_KBOT, rand_coef_row());
            set_size($urandom_range(3, 8), $urandom_range(3, 6));
            send_frame(cur_frame_words(), 1'b1, 0);
        end
    endtask

    // mode 3: counters and line memory move on, no results
    task automatic test_mode_off();
        settle();
        write_reg(REG_KMODE, CFG_DATA_W'(KM_OFF));
        set_size(6, 5);
        send_frame(30, 1'b1, 0);
        settle();
        write_reg(REG_KMODE, CFG_DATA_W'(KM_SOBEL_X));
        send_frame(30, 1'b0, 0);
    endtask

    // wide frame over many columns, then a tall narrow frame
    task automatic test_frame_extremes();
        settle();
        write_reg(REG_KMODE, CFG_DATA_W'(KM_SOBEL_Y));
        set_size(130, 3);
        send_frame(cur_frame_words(), 1'b1, 0);
        settle();
        write_reg(REG_KMODE, CFG_DATA_W'(KM_SOBEL_X));
        set_size(3, 40);
        send_frame(cur_frame_words(), 1'b1, 0);
    endtask

    // pause mid-frame until drained, frame starts in mid-frame
    task automatic test_restart_and_pause();
        settle();
        set_size(9, 7);
        send_frame(30, 1'b1, 0);
        wait_results();
        send_frame(33, 1'b0, 0);
        send_frame(40, 1'b1, 0);
        send_frame(63, 1'b1, 0);
        send_frame(100, 1'b0, 20);
    endtask

    // long hold on the result side fills the pipeline and stalls the input
    task automatic test_backpressure();
        settle();
        write_reg(REG_KMODE, CFG_DATA_W'(KM_SOBEL_Y));
        set_size(12, 8);
        hold_req = 1'b1;
        send_frame(cur_frame_words(), 1'b1, 0);
    endtask

    // random frames, kernels and sizes; broken frames and stray frame starts
    task automatic test_random_frames();
        int         sent, words;
        logic       fs_first;
        logic [1:0] mode;
        sent = 0;
        while (sent < RAND_WORDS) begin
            if (sent >= RAND_WORDS * 7 / 8) begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end else begin
                send_idle_on = ($urandom_range(0, 3) != 0);
                recv_idle_on = ($urandom_range(0, 3) != 0);
            end
            fs_first = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) != 0) begin
                settle();
                mode = ($urandom_range(0, 9) == 0) ? KM_OFF : 2'($urandom_range(0, 2));
                write_reg(REG_KMODE, {14'($urandom), 32'($urandom), mode});
                if (mode == KM_USER || $urandom_range(0, 3) == 0) begin
                    write_reg(REG_KTOP, rand_coef_row());
                    write_reg(REG_KMID, rand_coef_row());
                    write_reg(REG_KBOT, rand_coef_row());
                end
                set_size($urandom_range(0, 16), $urandom_range(0, 10));
                fs_first = 1'b1;
            end
            words = cur_frame_words();
            if ($urandom_range(0, 7) == 0) words = $urandom_range(1, words);
            send_frame(words, fs_first, 150);
            sent += words;
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        model_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;

        test_sobel_directed();
        test_user_kernel();
        test_mode_off();
        test_frame_extremes();
        test_restart_and_pause();
        test_backpressure();
        test_random_frames();

        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        settle();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
sv/c3sg_pkg.sv
sv/c3sg_ram.sv
sv/c3sg_line_buf.sv
sv/c3sg_window_mac.sv
sv/c3sg_scale.sv
sv/conv3x3_sobel_gradient.sv
tb/tb_conv3x3_sobel_gradient.sv
